// File: hdl/lgmc_pkg.sv
// package for the linear gamut matrix converter
// widths, register and mode codes, matrix coefficient tables; no dependencies
`default_nettype none

package lgmc_pkg;

	localparam int PIX_W     = 32;
	localparam int GAIN_W    = 32;
	localparam int GAIN_FRAC = 16;
	localparam int COEF_W    = 26;
	localparam int COEF_FRAC = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// gain product: signed pixel times unsigned gain
	localparam int GPROD_W = PIX_W + GAIN_W;
	// matrix product and three-term sum
	localparam int MPROD_W = COEF_W + PIX_W;
	localparam int ACC_W   = MPROD_W + 2;

	typedef enum logic [1:0] {
		MODE_GAIN_709_TO_2020 = 2'd0,
		MODE_2020_TO_709      = 2'd1,
		MODE_P3_TO_709        = 2'd2,
		MODE_IDENTITY         = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 2'd0,
		REG_GAIN_RED   = 2'd1,
		REG_GAIN_GREEN = 2'd2,
		REG_GAIN_BLUE  = 2'd3
	} reg_index_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PIX_W-1:0]  pix_t;

	// stage advance enables, shared by the datapath parts
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// seven-decimal constant to 24 fractional bits, round to nearest
	function automatic longint cpos(longint n);
		return (n * 64'sd16777216 + 64'sd5000000) / 64'sd10000000;
	endfunction

	localparam coef_t C_ONE  = coef_t'(64'sd1 <<< COEF_FRAC);
	localparam coef_t C_ZERO = coef_t'(0);

	localparam coef_t MAT_709_2020 [9] = '{
		coef_t'(cpos(6274039)), coef_t'(cpos(3292830)), coef_t'(cpos(433131)),
		coef_t'(cpos(690973)),  coef_t'(cpos(9195404)), coef_t'(cpos(113623)),
		coef_t'(cpos(163914)),  coef_t'(cpos(880133)),  coef_t'(cpos(8955953))
	};

	localparam coef_t MAT_2020_709 [9] = '{
		coef_t'(cpos(16604910)),  coef_t'(-cpos(5876411)),  coef_t'(-cpos(728499)),
		coef_t'(-cpos(1245505)),  coef_t'(cpos(11328999)),  coef_t'(-cpos(83494)),
		coef_t'(-cpos(181508)),   coef_t'(-cpos(1005789)),  coef_t'(cpos(11187297))
	};

	localparam coef_t MAT_P3_709 [9] = '{
		coef_t'(cpos(12249401)), coef_t'(-cpos(2249401)),  C_ZERO,
		coef_t'(-cpos(420569)),  coef_t'(cpos(10420569)),  C_ZERO,
		coef_t'(-cpos(196376)),  coef_t'(-cpos(786361)),   coef_t'(cpos(10982737))
	};

	localparam coef_t MAT_IDENT [9] = '{
		C_ONE,  C_ZERO, C_ZERO,
		C_ZERO, C_ONE,  C_ZERO,
		C_ZERO, C_ZERO, C_ONE
	};

	// coefficient of entry idx (row * 3 + column) for a mode
	function automatic coef_t coef_sel(mode_t m, logic [3:0] idx);
		coef_t c;
		case (m)
			MODE_GAIN_709_TO_2020: c = MAT_709_2020[idx];
			MODE_2020_TO_709:      c = MAT_2020_709[idx];
			MODE_P3_TO_709:        c = MAT_P3_709[idx];
			default:               c = MAT_IDENT[idx];
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/lgmc_in_if.sv
// input pixel channel: valid, ready and the three linear components
// depends on lgmc_pkg
`default_nettype none

interface lgmc_in_if
	import lgmc_pkg::*;
;
	logic valid;
	logic ready;
	pix_t in_red;
	pix_t in_green;
	pix_t in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

`default_nettype wire

// File: hdl/lgmc_out_if.sv
// result pixel channel: valid, ready and the three converted components
// depends on lgmc_pkg
`default_nettype none

interface lgmc_out_if
	import lgmc_pkg::*;
;
	logic valid;
	logic ready;
	pix_t out_red;
	pix_t out_green;
	pix_t out_blue;

	modport source (output valid, output out_red, output out_green, output out_blue,
		input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		output ready);
endinterface

`default_nettype wire

// File: hdl/lgmc_gain.sv
// one channel of the gain step: multiply stage and round/saturate stage
// depends on lgmc_pkg
`default_nettype none

module lgmc_gain
	import lgmc_pkg::*;
(
	input  wire logic              clk,
	input  wire stage_en_t         en,
	input  wire pix_t              px,
	input  wire logic [GAIN_W-1:0] gain,
	input  wire logic              use_gain_s1,
	output pix_t                   vec_s2
);

	localparam int SHR_W = GPROD_W - GAIN_FRAC;
	localparam logic signed [GPROD_W-1:0] HALF = GPROD_W'(64'sd1 <<< (GAIN_FRAC - 1));

	logic signed [GPROD_W-1:0] prod_s1;
	pix_t                      px_s1;
	logic signed [GPROD_W-1:0] rnd;
	logic signed [SHR_W-1:0]   shr;
	logic                      fits;
	pix_t                      sat;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= GPROD_W'(px * $signed({1'b0, gain}));
			px_s1   <= px;
		end
	end

	assign rnd  = prod_s1 + HALF;
	assign shr  = rnd[GPROD_W-1:GAIN_FRAC];
	assign fits = (&shr[SHR_W-1:PIX_W-1]) | ~(|shr[SHR_W-1:PIX_W-1]);

	always_comb begin
		if (fits) begin
			sat = shr[PIX_W-1:0];
		end else if (shr[SHR_W-1]) begin
			sat = {1'b1, {(PIX_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(PIX_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			vec_s2 <= use_gain_s1 ? sat : px_s1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/lgmc_matrix.sv
// 3x3 matrix step: nine product registers, then row sum, round, saturate, clamp
// depends on lgmc_pkg
`default_nettype none

module lgmc_matrix
	import lgmc_pkg::*;
(
	input  wire logic      clk,
	input  wire stage_en_t en,
	input  wire mode_t     mode_s2,
	input  wire mode_t     mode_s3,
	input  wire pix_t      vec_s2 [3],
	output pix_t           res_s4 [3]
);

	localparam int SHR_W = ACC_W - COEF_FRAC;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

	logic signed [MPROD_W-1:0] prod_s3 [9];

	for (genvar k = 0; k < 9; k++) begin : g_prod
		always_ff @(posedge clk) begin
			if (en.s3) begin
				prod_s3[k] <= MPROD_W'(coef_sel(mode_s2, 4'(k)) * vec_s2[k % 3]);
			end
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [ACC_W-1:0] acc;
		logic signed [SHR_W-1:0] shr;
		logic                    fits;
		pix_t                    sat;

		assign acc = ACC_W'(prod_s3[r*3]) + ACC_W'(prod_s3[r*3+1])
			+ ACC_W'(prod_s3[r*3+2]) + HALF;
		assign shr  = acc[ACC_W-1:COEF_FRAC];
		assign fits = (&shr[SHR_W-1:PIX_W-1]) | ~(|shr[SHR_W-1:PIX_W-1]);

		always_comb begin
			if (fits) begin
				sat = shr[PIX_W-1:0];
			end else if (shr[SHR_W-1]) begin
				sat = {1'b1, {(PIX_W-1){1'b0}}};
			end else begin
				sat = {1'b0, {(PIX_W-1){1'b1}}};
			end
			// negatives clamp to zero in the gain mode
			if (mode_s3 == MODE_GAIN_709_TO_2020 && sat[PIX_W-1]) begin
				sat = '0;
			end
		end

		always_ff @(posedge clk) begin
			if (en.s4) begin
				res_s4[r] <= sat;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/linear_gamut_matrix_converter.sv
// top level of the linear gamut matrix converter
// depends on lgmc_pkg, lgmc_in_if, lgmc_out_if, lgmc_gain, lgmc_matrix
`default_nettype none

// Converts one linear RGB pixel (signed, 16 fractional bits) per clock while
// the output is ready. The mode register picks gain plus Rec.709 to Rec.2020
// with negatives clamped to zero, Rec.2020 to Rec.709, Display P3 to Rec.709,
// or pass-through; the three gain registers (unsigned Q16.16) only act in the
// gain mode. Every result saturates to the signed 32-bit range. The pipe has
// four stages, the first one loaded at the input transfer edge: gain multiply,
// gain round/saturate and mode select, nine coefficient multipliers, and row
// sum with round/saturate/clamp. Each stage holds its own valid bit and only
// stalls while it is full and the stage after it cannot advance, so bubbles
// close up and a waiting result does not block input transfers until the
// whole pipe is full. Configuration writes take effect on the next clock; the
// mode travels with each pixel through the pipe.
module linear_gamut_matrix_converter
	import lgmc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	lgmc_in_if.sink                   pixel,
	lgmc_out_if.source                converted,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration registers
	mode_t             mode_q;
	logic [GAIN_W-1:0] gain_red_q;
	logic [GAIN_W-1:0] gain_green_q;
	logic [GAIN_W-1:0] gain_blue_q;

	// stage valid bits and the mode that rides along
	logic      v_s1, v_s2, v_s3, v_s4;
	mode_t     mode_s1, mode_s2, mode_s3, mode_s4;
	stage_en_t en;

	pix_t vec_s2 [3];
	pix_t res_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDENTITY;
			gain_red_q   <= GAIN_W'(1 << GAIN_FRAC);
			gain_green_q <= GAIN_W'(1 << GAIN_FRAC);
			gain_blue_q  <= GAIN_W'(1 << GAIN_FRAC);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MODE:       mode_q       <= mode_t'(cfg_data[1:0]);
				REG_GAIN_RED:   gain_red_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_GREEN: gain_green_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_BLUE:  gain_blue_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage advances when it is empty or the next one advances
	assign en.s4 = ~v_s4 | converted.ready;
	assign en.s3 = ~v_s3 | en.s4;
	assign en.s2 = ~v_s2 | en.s3;
	assign en.s1 = ~v_s1 | en.s2;

	assign pixel.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= pixel.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// mode payload, no reset needed
	always_ff @(posedge clk) begin
		if (en.s1) mode_s1 <= mode_q;
		if (en.s2) mode_s2 <= mode_s1;
		if (en.s3) mode_s3 <= mode_s2;
		if (en.s4) mode_s4 <= mode_s3;
	end

	// gain step per channel, raw pixel selected outside the gain mode
	lgmc_gain u_gain_red (
		.clk         (clk),
		.en          (en),
		.px          (pixel.in_red),
		.gain        (gain_red_q),
		.use_gain_s1 (mode_s1 == MODE_GAIN_709_TO_2020),
		.vec_s2      (vec_s2[0])
	);

	lgmc_gain u_gain_green (
		.clk         (clk),
		.en          (en),
		.px          (pixel.in_green),
		.gain        (gain_green_q),
		.use_gain_s1 (mode_s1 == MODE_GAIN_709_TO_2020),
		.vec_s2      (vec_s2[1])
	);

	lgmc_gain u_gain_blue (
		.clk         (clk),
		.en          (en),
		.px          (pixel.in_blue),
		.gain        (gain_blue_q),
		.use_gain_s1 (mode_s1 == MODE_GAIN_709_TO_2020),
		.vec_s2      (vec_s2[2])
	);

	// identity mode runs through the matrix with unit diagonal, which is exact
	lgmc_matrix u_matrix (
		.clk     (clk),
		.en      (en),
		.mode_s2 (mode_s2),
		.mode_s3 (mode_s3),
		.vec_s2  (vec_s2),
		.res_s4  (res_s4)
	);

	assign converted.valid     = v_s4;
	assign converted.out_red   = res_s4[0];
	assign converted.out_green = res_s4[1];
	assign converted.out_blue  = res_s4[2];

	// an input transfer always lands in the first stage
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> v_s1)
		else $error("input transfer did not reach stage one");

	// an empty output stage must let the whole pipe move
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!converted.valid |-> pixel.ready)
		else $error("pipe stalled with an empty output stage");

	// gain mode results are clamped to non-negative
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(converted.valid && mode_s4 == MODE_GAIN_709_TO_2020) |->
		(!converted.out_red[PIX_W-1] && !converted.out_green[PIX_W-1]
			&& !converted.out_blue[PIX_W-1]))
		else $error("negative result in clamped mode");

	// a stalled stage three item must not advance into a full, stalled output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(converted.valid && !converted.ready) |=> converted.valid)
		else $error("held result lost");

endmodule

`default_nettype wire
